>>> hdl/fqsb_pkg.sv
`default_nettype none

package fqsb_pkg;

  localparam int GRID_W    = 10;
  localparam int SIZE_W    = 9;
  localparam int HEIGHT_W  = 8;
  localparam int WTEX_W    = 8;
  localparam int HANDLE_W  = 16;
  localparam int SCALE_W   = 16;
  localparam int COLOR_W   = 24;
  localparam int POS_W     = 11;
  localparam int TEXC_W    = 24;
  localparam int STRIP_W   = 16;
  localparam int LERR_W    = 7;
  localparam int PROD_W    = SCALE_W + POS_W;

  localparam int IN_DATA_W  = 192;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 152;

  localparam logic [LERR_W-1:0] LIGHT_ERROR_RST = LERR_W'(8);

  localparam logic [1:0] MODE_FLOOR = 2'd0;
  localparam logic [1:0] MODE_CEIL  = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  typedef enum logic [0:0] {
    KIND_VERTEX = 1'b0,
    KIND_STRIP  = 1'b1
  } fqsb_kind_e;

  typedef enum logic [2:0] {
    PH_CLOSE = 3'd0,
    PH_LEAD0 = 3'd1,
    PH_LEAD1 = 3'd2,
    PH_ROW0  = 3'd3,
    PH_ROW1  = 3'd4
  } fqsb_phase_e;

  // input beat layout, lowest field last
  typedef struct packed {
    logic [2:0]          pad;
    logic [COLOR_W-1:0]  color_d;
    logic [COLOR_W-1:0]  color_c;
    logic [COLOR_W-1:0]  color_b;
    logic [COLOR_W-1:0]  color_a;
    logic [31:0]         tex_scale;
    logic [HANDLE_W-1:0] tex_handle;
    logic [WTEX_W-1:0]   texture_index;
    logic [HEIGHT_W-1:0] height;
    logic [SIZE_W-1:0]   quad_size;
    logic [GRID_W-1:0]   grid_y;
    logic [GRID_W-1:0]   grid_x;
  } fqsb_in_beat_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [GRID_W-1:0]   grid_x;
    logic [GRID_W-1:0]   grid_y;
    logic [SIZE_W-1:0]   quad_size;
    logic [HEIGHT_W-1:0] height;
    logic [WTEX_W-1:0]   texture_index;
    logic [HANDLE_W-1:0] tex_handle;
    logic [31:0]         tex_scale;
    logic [COLOR_W-1:0]  color_a;
    logic [COLOR_W-1:0]  color_b;
    logic [COLOR_W-1:0]  color_c;
    logic [COLOR_W-1:0]  color_d;
  } fqsb_item_t;

  // everything the emitter needs to produce the beats of one quad
  typedef struct packed {
    logic                has_close;
    logic                has_lead;
    logic                has_row;
    logic                ceil;
    logic                drop;
    logic [GRID_W-1:0]   x;
    logic [GRID_W-1:0]   y;
    logic [SIZE_W-1:0]   size;
    logic [HEIGHT_W-1:0] height;
    logic [SCALE_W-1:0]  u_scale;
    logic [SCALE_W-1:0]  v_scale;
    logic [COLOR_W-1:0]  color_a;
    logic [COLOR_W-1:0]  color_b;
    logic [COLOR_W-1:0]  color_c;
    logic [COLOR_W-1:0]  color_d;
    logic [STRIP_W-1:0]  strip_texture;
    logic [STRIP_W-1:0]  strip_first;
    logic [STRIP_W-1:0]  strip_count;
  } fqsb_plan_t;

  typedef struct packed {
    logic                pad;
    logic [STRIP_W-1:0]  strip_count;
    logic [STRIP_W-1:0]  strip_first;
    logic [STRIP_W-1:0]  strip_texture;
    logic                drop_prev;
    logic [COLOR_W-1:0]  vert_color;
    logic [TEXC_W-1:0]   tex_v;
    logic [TEXC_W-1:0]   tex_u;
    logic [HEIGHT_W-1:0] vert_height;
    logic [POS_W-1:0]    pos_y;
    logic [POS_W-1:0]    pos_x;
  } fqsb_out_beat_t;

  // every rgb channel strictly closer than lim
  function automatic logic fqsb_near(input logic [COLOR_W-1:0] a,
                                     input logic [COLOR_W-1:0] b,
                                     input logic [7:0]         lim);
    logic       ok;
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] d;
    ok = 1'b1;
    for (int s = 0; s < 3; s++) begin
      ca = a[s*8 +: 8];
      cb = b[s*8 +: 8];
      d  = (ca > cb) ? (ca - cb) : (cb - ca);
      if (!(d < lim)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> hdl/fqsb_plan.sv
`default_nettype none

module fqsb_plan #(
  parameter int INDEX_BITS = 16,
  parameter int COORD_BITS = 10
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [fqsb_pkg::LERR_W-1:0]    cfg_wdata_i,
  input  wire                           take_i,
  input  fqsb_pkg::fqsb_item_t          item_i,
  output fqsb_pkg::fqsb_plan_t          plan_o
);
  import fqsb_pkg::*;

  localparam int CW = (COORD_BITS < GRID_W) ? COORD_BITS : GRID_W;
  localparam logic [GRID_W-1:0] CRD_MASK = GRID_W'((64'd1 << CW) - 64'd1);
  localparam logic [INDEX_BITS-1:0] LEAD_STEP = INDEX_BITS'(4);
  localparam logic [INDEX_BITS-1:0] ROW_STEP  = INDEX_BITS'(2);

  logic [LERR_W-1:0]     light_error_q;
  logic                  open_q;
  logic [CW-1:0]         prev_x_q;
  logic [CW-1:0]         prev_y_q;
  logic [HEIGHT_W-1:0]   prev_height_q;
  logic [HANDLE_W-1:0]   prev_handle_q;
  logic [INDEX_BITS-1:0] strip_start_q;
  logic [INDEX_BITS-1:0] vi_q;
  logic [COLOR_W-1:0]    ref_c_q;
  logic [COLOR_W-1:0]    ref_d_q;
  logic [COLOR_W-1:0]    last_col_q;
  logic [COLOR_W-1:0]    second_col_q;

  logic [GRID_W-1:0]     x_m;
  logic [GRID_W-1:0]     y_m;
  logic [POS_W-1:0]      y_next;
  logic                  is_close;
  logic                  is_ceil;
  logic                  first;
  logic                  merge;
  logic [7:0]            lim;
  logic [COLOR_W-1:0]    row0_col;
  logic [COLOR_W-1:0]    row1_col;

  always_comb begin
    x_m      = item_i.grid_x & CRD_MASK;
    y_m      = item_i.grid_y & CRD_MASK;
    is_close = (item_i.mode >= MODE_CLOSE);
    is_ceil  = (item_i.mode == MODE_CEIL);
    y_next   = POS_W'(prev_y_q) + POS_W'(item_i.quad_size);
    first    = !open_q || (POS_W'(y_m) != y_next) ||
               (item_i.tex_handle != prev_handle_q) ||
               (item_i.height != prev_height_q) ||
               (x_m != GRID_W'(prev_x_q));
    lim      = {light_error_q, 1'b0};
    merge    = (fqsb_near(ref_c_q, item_i.color_c, lim) &&
                fqsb_near(ref_d_q, item_i.color_d, lim)) ||
               (item_i.texture_index == '0);
    row0_col = is_ceil ? item_i.color_c : item_i.color_d;
    row1_col = is_ceil ? item_i.color_d : item_i.color_c;
  end

  always_comb begin
    plan_o.has_close     = open_q && (is_close || first);
    plan_o.has_lead      = !is_close && first;
    plan_o.has_row       = !is_close;
    plan_o.ceil          = is_ceil;
    plan_o.drop          = !is_close && !first && merge;
    plan_o.x             = x_m;
    plan_o.y             = y_m;
    plan_o.size          = item_i.quad_size;
    plan_o.height        = item_i.height;
    plan_o.u_scale       = item_i.tex_scale[15:0];
    plan_o.v_scale       = item_i.tex_scale[31:16];
    plan_o.color_a       = item_i.color_a;
    plan_o.color_b       = item_i.color_b;
    plan_o.color_c       = item_i.color_c;
    plan_o.color_d       = item_i.color_d;
    plan_o.strip_texture = prev_handle_q;
    plan_o.strip_first   = STRIP_W'(strip_start_q);
    plan_o.strip_count   = STRIP_W'(vi_q - strip_start_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_error_q <= LIGHT_ERROR_RST;
    end else if (cfg_we_i) begin
      light_error_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q        <= 1'b0;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      prev_height_q <= '0;
      prev_handle_q <= '0;
      strip_start_q <= '0;
      vi_q          <= '0;
      ref_c_q       <= '0;
      ref_d_q       <= '0;
      last_col_q    <= '0;
      second_col_q  <= '0;
    end else if (take_i) begin
      if (is_close) begin
        open_q <= 1'b0;
      end else begin
        prev_y_q     <= y_m[CW-1:0];
        last_col_q   <= row1_col;
        second_col_q <= row0_col;
        if (first) begin
          open_q        <= 1'b1;
          strip_start_q <= vi_q;
          prev_handle_q <= item_i.tex_handle;
          prev_height_q <= item_i.height;
          prev_x_q      <= x_m[CW-1:0];
          ref_c_q       <= item_i.color_a;
          ref_d_q       <= item_i.color_b;
          vi_q          <= vi_q + LEAD_STEP;
        end else if (!merge) begin
          // unmerged row: reference moves to the last two vertices
          ref_c_q <= last_col_q;
          ref_d_q <= second_col_q;
          vi_q    <= vi_q + ROW_STEP;
        end
      end
    end
  end

  a_close_shuts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && is_close |=> !open_q)
    else $error("strip still open after close");

  a_quad_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !is_close |=> open_q)
    else $error("no open strip after quad");

  a_new_strip_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !is_close && first |=> vi_q == $past(vi_q) + LEAD_STEP)
    else $error("vertex index wrong after new strip");

endmodule

`default_nettype wire

>>> hdl/fqsb_emit.sv
`default_nettype none

module fqsb_emit (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      load_i,
  input  fqsb_pkg::fqsb_plan_t     plan_i,
  output logic                     plan_ready_o,
  input  wire                      out_ready_i,
  output logic                     out_valid_o,
  output fqsb_pkg::fqsb_out_beat_t out_beat_o,
  output fqsb_pkg::fqsb_kind_e     out_kind_o,
  output logic                     out_last_o
);
  import fqsb_pkg::*;

  logic           plan_valid_q;
  fqsb_plan_t     plan_q;
  fqsb_phase_e    phase_q;
  fqsb_phase_e    phase_next;
  fqsb_phase_e    phase_start;
  logic           phase_last;
  logic           adv;

  logic           out_valid_q;
  fqsb_out_beat_t out_q;
  fqsb_kind_e     out_kind_q;
  logic           out_last_q;

  fqsb_out_beat_t rec;
  fqsb_kind_e     rec_kind;
  logic           far_x;
  logic           far_y;
  logic [POS_W-1:0]  px;
  logic [POS_W-1:0]  py;
  logic [PROD_W-1:0] prod_u;
  logic [PROD_W-1:0] prod_v;

  always_comb begin
    if (plan_i.has_close) begin
      phase_start = PH_CLOSE;
    end else if (plan_i.has_lead) begin
      phase_start = PH_LEAD0;
    end else begin
      phase_start = PH_ROW0;
    end
  end

  // next phase
  always_comb begin
    phase_next = PH_ROW1;
    phase_last = 1'b0;
    case (phase_q)
      PH_CLOSE: begin
        if (plan_q.has_lead) begin
          phase_next = PH_LEAD0;
        end else if (plan_q.has_row) begin
          phase_next = PH_ROW0;
        end else begin
          phase_last = 1'b1;
        end
      end
      PH_LEAD0: phase_next = PH_LEAD1;
      PH_LEAD1: phase_next = PH_ROW0;
      PH_ROW0:  phase_next = PH_ROW1;
      PH_ROW1:  phase_last = 1'b1;
      default:  phase_last = 1'b1;
    endcase
  end

  assign adv          = plan_valid_q && (!out_valid_q || out_ready_i);
  assign plan_ready_o = !plan_valid_q || (adv && phase_last);

  // beat contents for the current phase
  always_comb begin
    far_y = (phase_q == PH_ROW0) || (phase_q == PH_ROW1);
    // ceiling quads walk the row in the opposite x order
    far_x = ((phase_q == PH_LEAD1) || (phase_q == PH_ROW1)) ^ plan_q.ceil;
    px    = POS_W'(plan_q.x) + (far_x ? POS_W'(plan_q.size) : '0);
    py    = POS_W'(plan_q.y) + (far_y ? POS_W'(plan_q.size) : '0);
    prod_u = PROD_W'(plan_q.u_scale) * PROD_W'(px);
    prod_v = PROD_W'(plan_q.v_scale) * PROD_W'(py);

    rec             = '0;
    rec_kind        = KIND_VERTEX;
    rec.pos_x       = px;
    rec.pos_y       = py;
    rec.vert_height = plan_q.height;
    rec.tex_u       = (|prod_u[PROD_W-1:TEXC_W]) ? '1 : prod_u[TEXC_W-1:0];
    rec.tex_v       = (|prod_v[PROD_W-1:TEXC_W]) ? '1 : prod_v[TEXC_W-1:0];
    rec.drop_prev   = (phase_q == PH_ROW0) && plan_q.drop;
    case ({far_y, far_x})
      2'b00:   rec.vert_color = plan_q.color_a;
      2'b01:   rec.vert_color = plan_q.color_b;
      2'b11:   rec.vert_color = plan_q.color_c;
      default: rec.vert_color = plan_q.color_d;
    endcase
    if (phase_q == PH_CLOSE) begin
      rec               = '0;
      rec_kind          = KIND_STRIP;
      rec.strip_texture = plan_q.strip_texture;
      rec.strip_first   = plan_q.strip_first;
      rec.strip_count   = plan_q.strip_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_valid_q <= 1'b0;
      phase_q      <= PH_CLOSE;
    end else if (load_i) begin
      plan_valid_q <= plan_i.has_close || plan_i.has_lead || plan_i.has_row;
      phase_q      <= phase_start;
    end else if (adv) begin
      if (phase_last) begin
        plan_valid_q <= 1'b0;
      end else begin
        phase_q <= phase_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      plan_q <= plan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q      <= rec;
      out_kind_q <= rec_kind;
      out_last_q <= phase_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  a_close_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan_valid_q && (phase_q == PH_CLOSE) |-> plan_q.has_close)
    else $error("strip beat without a strip to close");

  a_lead_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plan_valid_q && ((phase_q == PH_LEAD0) || (phase_q == PH_LEAD1))
      |-> plan_q.has_lead)
    else $error("leading vertex on a continued strip");

  a_vertex_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == KIND_VERTEX)
      |-> (out_q.strip_texture == '0) && (out_q.strip_first == '0) &&
          (out_q.strip_count == '0))
    else $error("vertex beat carries strip fields");

endmodule

`default_nettype wire

>>> hdl/floor_quad_strip_builder_core.sv
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  one quad or a close command
// m_axis    out  m_axis_tvalid/m_axis_tready  vertex or strip beats, tlast on the final one
// cfg       in   cfg_we_i                     light_error
//
// a quad yields up to five beats (strip close, two leading vertices, two row vertices)
// through one output register, one beat per cycle while m_axis_tready is high; a new
// strip gives four, five if closing one, a continued row two, a close one if one is open
// a quad waits in the input register while the previous one's beats drain
// m_axis_tready low stalls the beat sequence; nothing is dropped
// reset clears the strip state and sets light_error to 8
`default_nettype none

module floor_quad_strip_builder_core #(
  parameter int INDEX_BITS = 16,
  parameter int COORD_BITS = 10
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [fqsb_pkg::LERR_W-1:0]         cfg_wdata_i,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // grid_x, grid_y, quad_size, height, texture_index, tex_handle, tex_scale,
  // color_a, color_b, color_c, color_d
  input  wire [fqsb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // mode
  input  wire [fqsb_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // pos_x, pos_y, vert_height, tex_u, tex_v, vert_color, drop_prev,
  // strip_texture, strip_first, strip_count
  output logic [fqsb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // kind
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);
  import fqsb_pkg::*;

  fqsb_in_beat_t  in_beat;
  fqsb_item_t     in_d;
  fqsb_item_t     in_q;
  logic           in_valid_q;
  logic           take;
  logic           plan_ready;
  fqsb_plan_t     plan;
  fqsb_out_beat_t out_beat;
  fqsb_kind_e     out_kind;

  assign in_beat = fqsb_in_beat_t'(s_axis_tdata);

  always_comb begin
    in_d.mode          = s_axis_tuser;
    in_d.grid_x        = in_beat.grid_x;
    in_d.grid_y        = in_beat.grid_y;
    in_d.quad_size     = in_beat.quad_size;
    in_d.height        = in_beat.height;
    in_d.texture_index = in_beat.texture_index;
    in_d.tex_handle    = in_beat.tex_handle;
    in_d.tex_scale     = in_beat.tex_scale;
    in_d.color_a       = in_beat.color_a;
    in_d.color_b       = in_beat.color_b;
    in_d.color_c       = in_beat.color_c;
    in_d.color_d       = in_beat.color_d;
  end

  assign take          = in_valid_q && plan_ready;
  assign s_axis_tready = !in_valid_q || plan_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_d;
    end
  end

  fqsb_plan #(
    .INDEX_BITS (INDEX_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_plan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (in_q),
    .plan_o      (plan)
  );

  fqsb_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (take),
    .plan_i       (plan),
    .plan_ready_o (plan_ready),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_beat_o   (out_beat),
    .out_kind_o   (out_kind),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = out_beat;
  assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire
